// File: hw/rtl/rle_double_byte_compressor_assert.svh
// ----------------------------------------------------------------------------
// RLE compressor assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RLE_DOUBLE_BYTE_COMPRESSOR_ASSERT_SVH
`define RLE_DOUBLE_BYTE_COMPRESSOR_ASSERT_SVH

// same-cycle implication
`define RLEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RLEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rlec_pkg.sv
// ----------------------------------------------------------------------------
// RLE compressor package
// Shared constants and the queue entry type passed from front to back end.
// ----------------------------------------------------------------------------
package rlec_pkg;

   localparam int unsigned CapWidth   = 24;
   localparam logic [7:0]  MaxRun     = 8'd255;
   localparam logic [7:0]  TripleMin  = 8'd3;
   localparam logic [CapWidth-1:0] Headroom = CapWidth'(3);
   localparam logic [CapWidth-1:0] CapReset = {CapWidth{1'b1}};
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned MaxBytes   = 4;

   // one accepted beat's worth of results
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [1:0]               nres_m1;
      logic                     has_byte;
      logic                     last;
      logic                     trunc;
      logic [CapWidth-1:0]      total;
   } entry_type;

endpackage

// File: hw/rtl/rlec_front.sv
// ----------------------------------------------------------------------------
// RLE compressor front end
// Tracks runs, applies the capacity check per token and builds one queue
// entry per accepted input beat that yields results or ends the stream.
// ----------------------------------------------------------------------------
module rlec_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   in_byte,
   input  logic                         in_last,
   input  logic                         cap_we,
   input  logic [rlec_pkg::CapWidth-1:0] cap_wdata,
   output logic                         enq,
   output rlec_pkg::entry_type          enq_entry
);

   logic [7:0]                    run_value_ff, run_value_in;
   logic [7:0]                    run_length_ff, run_length_in;
   logic [rlec_pkg::CapWidth-1:0] bytes_written_ff, bytes_written_in;
   logic                          stopped_ff, stopped_in;
   logic [rlec_pkg::CapWidth-1:0] cap_ff, cap_in;

   logic                          extend;
   logic [7:0]                    fl_len;
   logic                          fl_valid;
   logic [2:0]                    tok_v;
   logic                          tok_tri;
   logic [7:0]                    tok_val [3];
   logic [rlec_pkg::CapWidth-1:0] bw_v;
   logic                          st_v;
   logic [2:0]                    cnt;
   logic [rlec_pkg::MaxBytes-1:0][7:0] obytes;

   always_comb begin
      extend   = (run_length_ff != '0) && (in_byte == run_value_ff)
                 && (run_length_ff != rlec_pkg::MaxRun);
      fl_len   = extend ? (run_length_ff + 8'd1) : run_length_ff;
      fl_valid = extend ? in_last : (run_length_ff != '0);
      tok_v[0] = fl_valid;
      tok_v[1] = fl_valid && (fl_len == 8'd2);
      tok_v[2] = !extend && in_last;
      tok_tri  = fl_len >= rlec_pkg::TripleMin;
      tok_val[0] = run_value_ff;
      tok_val[1] = run_value_ff;
      tok_val[2] = in_byte;

      bw_v   = bytes_written_ff;
      st_v   = stopped_ff;
      cnt    = '0;
      obytes = '0;
      for (int i = 0; i < 3; i++) begin
         if (tok_v[i] && !st_v) begin
            if (({1'b0, bw_v} + {1'b0, rlec_pkg::Headroom}) < {1'b0, cap_ff}) begin
               if ((i == 0) && tok_tri) begin
                  obytes[0] = tok_val[0];
                  obytes[1] = tok_val[0];
                  obytes[2] = fl_len;
                  cnt       = 3'd3;
                  bw_v      = bw_v + rlec_pkg::CapWidth'(3);
               end else begin
                  obytes[cnt[1:0]] = tok_val[i];
                  cnt              = cnt + 3'd1;
                  bw_v             = bw_v + rlec_pkg::CapWidth'(1);
               end
            end else begin
               st_v = 1'b1;
            end
         end
      end

      enq                = accept && ((cnt != '0) || in_last);
      enq_entry.bytes    = obytes;
      enq_entry.nres_m1  = (cnt == '0) ? 2'd0 : 2'(cnt - 3'd1);
      enq_entry.has_byte = cnt != '0;
      enq_entry.last     = in_last;
      enq_entry.trunc    = st_v;
      enq_entry.total    = bw_v;

      run_value_in     = run_value_ff;
      run_length_in    = run_length_ff;
      bytes_written_in = bytes_written_ff;
      stopped_in       = stopped_ff;
      if (accept) begin
         run_value_in     = extend ? run_value_ff : in_byte;
         run_length_in    = in_last ? 8'd0 : (extend ? fl_len : 8'd1);
         bytes_written_in = in_last ? '0 : bw_v;
         stopped_in       = in_last ? 1'b0 : st_v;
      end
      cap_in = cap_we ? cap_wdata : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff     <= '0;
         run_length_ff    <= '0;
         bytes_written_ff <= '0;
         stopped_ff       <= 1'b0;
         cap_ff           <= rlec_pkg::CapReset;
      end else begin
         run_value_ff     <= run_value_in;
         run_length_ff    <= run_length_in;
         bytes_written_ff <= bytes_written_in;
         stopped_ff       <= stopped_in;
         cap_ff           <= cap_in;
      end
   end

endmodule

// File: hw/rtl/rlec_queue.sv
// ----------------------------------------------------------------------------
// RLE compressor entry queue
// Small register queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module rlec_queue #(
   parameter int unsigned DEPTH = rlec_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  rlec_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop_en,
   output rlec_pkg::entry_type head,
   output logic                empty
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   rlec_pkg::entry_type store_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full     = count_ff == FullCnt;
      empty    = count_ff == '0;
      head     = store_ff[rd_ptr_ff];
      do_push  = push_en && !full;
      do_pop   = pop_en && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/rlec_back.sv
// ----------------------------------------------------------------------------
// RLE compressor back end
// Walks the bytes of the head entry one result beat at a time.
// ----------------------------------------------------------------------------
module rlec_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rlec_pkg::entry_type           head,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    out_byte,
   output logic                          out_has_byte,
   output logic                          out_item_last,
   output logic                          out_stream_end,
   output logic                          out_truncated,
   output logic [rlec_pkg::CapWidth-1:0] out_total
);

   logic [1:0] idx_ff, idx_in;
   logic       item_last;
   logic       stream_end;
   logic       take;

   always_comb begin
      item_last      = idx_ff == head.nres_m1;
      stream_end     = head.last && item_last;
      take           = pop && !q_empty;
      empty          = q_empty;
      q_pop          = take && item_last;
      out_byte       = head.bytes[idx_ff];
      out_has_byte   = head.has_byte;
      out_item_last  = item_last;
      out_stream_end = stream_end;
      out_truncated  = stream_end && head.trunc;
      out_total      = stream_end ? head.total : '0;
      idx_in         = idx_ff;
      if (take) begin
         idx_in = item_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: hw/rtl/rle_double_byte_compressor.sv
// An accepted beat with results is registered in the entry queue; its first result
// reaches the result ports once earlier entries are popped. Input: one beat per cycle
//   while the queue is not full; a beat's results (up to four) pop one at a time.
// The front end takes a beat whenever the queue has room, also during result stalls.
// Reset (synchronous) clears run state, byte count and queue; capacity returns to max.
// ----------------------------------------------------------------------------
// RLE double-byte compressor top level
// Run-length compressor with doubled-byte escape and output capacity limit.
// ----------------------------------------------------------------------------
module rle_double_byte_compressor #(
   parameter int unsigned QUEUE_DEPTH = rlec_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_in_last,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_out_has_byte,
   output logic                          rsp_out_item_last,
   output logic                          rsp_out_stream_end,
   output logic                          rsp_out_truncated,
   output logic [rlec_pkg::CapWidth-1:0] rsp_out_total,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlec_pkg::CapWidth-1:0] csr_output_capacity
);

   logic                accept;
   logic                enq;
   rlec_pkg::entry_type enq_entry;
   rlec_pkg::entry_type head;
   logic                q_empty;
   logic                q_pop;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   rlec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .cap_we    (csr_valid && csr_ready),
      .cap_wdata (csr_output_capacity),
      .enq       (enq),
      .enq_entry (enq_entry)
   );

   rlec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (enq),
      .push_data (enq_entry),
      .full      (full),
      .pop_en    (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   rlec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .out_byte       (rsp_out_byte),
      .out_has_byte   (rsp_out_has_byte),
      .out_item_last  (rsp_out_item_last),
      .out_stream_end (rsp_out_stream_end),
      .out_truncated  (rsp_out_truncated),
      .out_total      (rsp_out_total)
   );

endmodule

// File: hw/rtl/rlec_checker.sv
// ----------------------------------------------------------------------------
// RLE compressor port checker
// Watches the top-level ports for result framing and stall behaviour.
// ----------------------------------------------------------------------------
`include "rle_double_byte_compressor_assert.svh"

module rlec_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          empty,
   input logic                          pop,
   input logic [7:0]                    rsp_out_byte,
   input logic                          rsp_out_has_byte,
   input logic                          rsp_out_item_last,
   input logic                          rsp_out_stream_end,
   input logic                          rsp_out_truncated,
   input logic [rlec_pkg::CapWidth-1:0] rsp_out_total
);

   `RLEC_ASSERT_SAME(a_end_is_item_last, clock, reset,
      !empty && rsp_out_stream_end, rsp_out_item_last,
      "stream end beat not marked item last")
   `RLEC_ASSERT_SAME(a_bare_only_at_end, clock, reset,
      !empty && !rsp_out_has_byte, rsp_out_stream_end && (rsp_out_byte == 8'd0),
      "bare beat outside stream end")
   `RLEC_ASSERT_SAME(a_total_only_at_end, clock, reset,
      !empty && !rsp_out_stream_end, (rsp_out_total == '0) && !rsp_out_truncated,
      "total or truncation outside stream end")
   `RLEC_ASSERT_NEXT(a_stall_holds, clock, reset,
      !empty && !pop, !empty && $stable(rsp_out_byte) && $stable(rsp_out_stream_end),
      "stalled result changed")

endmodule

bind rle_double_byte_compressor rlec_checker u_rlec_checker (.*);
